FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/eyvm_pkg.sv
// package for the yxz view matrix block
`default_nettype none
package eyvm_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W = 34;
  localparam int TRIG_W = 16;
  localparam int Q14_ONE = 16384;
  localparam logic [33:0] CORDIC_K = 34'h026DD3B6A;
  localparam logic [33:0] HALF_TURN = 34'h080000000;
  localparam logic [33:0] QUARTER_TURN = 34'h040000000;

  function automatic logic [33:0] atan_turn(input int i);
    logic [33:0] r;
    case (i)
      0: r = 34'h020000000;
      1: r = 34'h012E4051E;
      2: r = 34'h009FB385B;
      3: r = 34'h0051111D4;
      4: r = 34'h0028B0D43;
      5: r = 34'h00145D7E1;
      6: r = 34'h000A2F61E;
      7: r = 34'h000517C55;
      8: r = 34'h00028BE53;
      9: r = 34'h000145F2F;
      10: r = 34'h0000A2F98;
      11: r = 34'h0000517CC;
      12: r = 34'h000028BE6;
      13: r = 34'h0000145F3;
      14: r = 34'h00000A2FA;
      15: r = 34'h00000517D;
      16: r = 34'h0000028BE;
      17: r = 34'h00000145F;
      18: r = 34'h000000A30;
      19: r = 34'h000000518;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;
endpackage
`default_nettype wire

FILE: hw/rtl/eyvm_cordic.sv
// pipelined cordic sine and cosine, one rotation per stage
`default_nettype none
module eyvm_cordic #(
  parameter int ANGLE_BITS = eyvm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] ang,
  output eyvm_pkg::trig_t            trig
);
  localparam int W = eyvm_pkg::CORDIC_W;
  localparam int N = eyvm_pkg::CORDIC_STEPS;
  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic signed [W-1:0] z_r [N+1];
  logic                flip_r [N+1];
  logic signed [W-1:0] z0;
  logic [31:0]         a32;
  logic signed [W-1:0] fx, fy, rx, ry;
  logic signed [W-1:0] cx, cy;

  assign a32 = {ang, {(32-ANGLE_BITS){1'b0}}};
  assign z0 = W'(signed'(a32));

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= eyvm_pkg::CORDIC_K;
      y_r[0] <= '0;
      if (z0 > signed'(eyvm_pkg::QUARTER_TURN)) begin
        z_r[0] <= z0 - signed'(eyvm_pkg::HALF_TURN);
        flip_r[0] <= 1'b1;
      end else if (z0 < -signed'(eyvm_pkg::QUARTER_TURN)) begin
        z_r[0] <= z0 + signed'(eyvm_pkg::HALF_TURN);
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - signed'(eyvm_pkg::atan_turn(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + signed'(eyvm_pkg::atan_turn(i));
        end
      end
    end
  end

  assign fx = flip_r[N] ? -x_r[N] : x_r[N];
  assign fy = flip_r[N] ? -y_r[N] : y_r[N];
  assign rx = (fx + W'(32768)) >>> 16;
  assign ry = (fy + W'(32768)) >>> 16;
  assign cx = (rx > W'(eyvm_pkg::Q14_ONE)) ? W'(eyvm_pkg::Q14_ONE) :
              (rx < -W'(eyvm_pkg::Q14_ONE)) ? -W'(eyvm_pkg::Q14_ONE) : rx;
  assign cy = (ry > W'(eyvm_pkg::Q14_ONE)) ? W'(eyvm_pkg::Q14_ONE) :
              (ry < -W'(eyvm_pkg::Q14_ONE)) ? -W'(eyvm_pkg::Q14_ONE) : ry;

  always_ff @(posedge clk) begin
    if (en) begin
      trig.c <= cx[eyvm_pkg::TRIG_W-1:0];
      trig.s <= cy[eyvm_pkg::TRIG_W-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/euler_yxz_view_matrix_top.sv
// an accepted input word passes the cordic pipelines, then stages a to f, to its output word
// throughput: one word per cycle while the output is not stalled, set by the cordic and multiply pipeline
// stalls freeze the whole pipeline; no word is lost or repeated
// reset: synchronous active low rst_n clears all valid bits
`default_nettype none
`include "assert_macros.svh"
module euler_yxz_view_matrix_top #(
  parameter int ANGLE_BITS = eyvm_pkg::ANGLE_BITS_DEF,
  parameter int COORD_BITS = eyvm_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic signed [COORD_BITS-1:0] in_pos_z,
  input  wire logic [ANGLE_BITS-1:0]        in_angle_x,
  input  wire logic [ANGLE_BITS-1:0]        in_angle_y,
  input  wire logic [ANGLE_BITS-1:0]        in_angle_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                out_side_x,
  output logic signed [15:0]                out_side_y,
  output logic signed [15:0]                out_side_z,
  output logic signed [15:0]                out_up_x,
  output logic signed [15:0]                out_up_y,
  output logic signed [15:0]                out_up_z,
  output logic signed [15:0]                out_fwd_x,
  output logic signed [15:0]                out_fwd_y,
  output logic signed [15:0]                out_fwd_z,
  output logic signed [COORD_BITS-1:0]      out_shift_x,
  output logic signed [COORD_BITS-1:0]      out_shift_y,
  output logic signed [COORD_BITS-1:0]      out_shift_z
);
  localparam int TD = eyvm_pkg::CORDIC_STEPS + 2;
  localparam int LAT = TD + 6;
  localparam int PW = COORD_BITS + 16;
  localparam int SW = COORD_BITS + 18;

  logic en;
  logic [LAT-1:0] vld_r;
  assign out_valid = vld_r[LAT-1];
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  eyvm_pkg::trig_t t1, t2, t3;
  eyvm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_c1 (.clk, .en, .ang(in_angle_z), .trig(t1));
  eyvm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_c2 (.clk, .en, .ang(in_angle_x), .trig(t2));
  eyvm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_c3 (.clk, .en, .ang(in_angle_y), .trig(t3));

  logic signed [COORD_BITS-1:0] px_r [TD+3];
  logic signed [COORD_BITS-1:0] py_r [TD+3];
  logic signed [COORD_BITS-1:0] pz_r [TD+3];
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= in_pos_x;
      py_r[0] <= in_pos_z;
      pz_r[0] <= in_pos_y;
      for (int i = 1; i < TD + 3; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  // stage a: pair products q28
  logic signed [31:0] c1c3_r, s1s2_r, c1s2_r, c3s1_r, c1s3_r, s1s3_r;
  logic signed [31:0] c2s3_r, c2c3_r, c2s1_r, c1c2_r;
  logic signed [15:0] s2a_r, s3a_r, c3a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= t1.c * t3.c;
      s1s2_r <= t1.s * t2.s;
      c1s2_r <= t1.c * t2.s;
      c3s1_r <= t3.c * t1.s;
      c1s3_r <= t1.c * t3.s;
      s1s3_r <= t1.s * t3.s;
      c2s3_r <= t2.c * t3.s;
      c2c3_r <= t2.c * t3.c;
      c2s1_r <= t2.c * t1.s;
      c1c2_r <= t1.c * t2.c;
      s2a_r <= t2.s;
      s3a_r <= t3.s;
      c3a_r <= t3.c;
    end
  end

  // stage b: q42 terms
  logic signed [47:0] e_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= (48'(c1c3_r) <<< 14) + 48'(s1s2_r) * 48'(s3a_r);
      e_r[1] <= 48'(c2s3_r) <<< 14;
      e_r[2] <= 48'(c1s2_r) * 48'(s3a_r) - (48'(c3s1_r) <<< 14);
      e_r[3] <= 48'(c3s1_r) * 48'(s2a_r) - (48'(c1s3_r) <<< 14);
      e_r[4] <= 48'(c2c3_r) <<< 14;
      e_r[5] <= 48'(c1s2_r) * 48'(c3a_r) + (48'(s1s3_r) <<< 14);
      e_r[6] <= 48'(c2s1_r) <<< 14;
      e_r[7] <= -(48'(s2a_r) <<< 28);
      e_r[8] <= 48'(c1c2_r) <<< 14;
    end
  end

  // stage c: round and clamp to q14
  logic signed [15:0] b_r [9];
  logic signed [47:0] rd [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rd[k] = (e_r[k] + 48'sd134217728) >>> 28;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (rd[k] > 48'sd16384) b_r[k] <= 16'sd16384;
        else if (rd[k] < -48'sd16384) b_r[k] <= -16'sd16384;
        else b_r[k] <= rd[k][15:0];
      end
    end
  end

  // stage d: basis times position
  logic signed [PW-1:0] m_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_r[3*k]   <= PW'(b_r[3*k])   * PW'(px_r[TD+2]);
        m_r[3*k+1] <= PW'(b_r[3*k+1]) * PW'(py_r[TD+2]);
        m_r[3*k+2] <= PW'(b_r[3*k+2]) * PW'(pz_r[TD+2]);
      end
    end
  end

  // stage e: sum and negate
  logic signed [SW-1:0] a_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k] <= -(SW'(m_r[3*k]) + SW'(m_r[3*k+1]) + SW'(m_r[3*k+2]));
      end
    end
  end

  // stage f: round and saturate
  logic signed [SW-1:0] ar [3];
  logic signed [COORD_BITS-1:0] sh_r [3];
  localparam logic signed [SW-1:0] LIM_HI = SW'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);
  always_comb begin
    for (int k = 0; k < 3; k++) ar[k] = (a_r[k] + SW'(8192)) >>> 14;
  end
  logic signed [15:0] bo_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (ar[k] > LIM_HI) sh_r[k] <= LIM_HI[COORD_BITS-1:0];
        else if (ar[k] < LIM_LO) sh_r[k] <= LIM_LO[COORD_BITS-1:0];
        else sh_r[k] <= ar[k][COORD_BITS-1:0];
      end
    end
  end

  // basis delay to line up with the shift result
  logic signed [15:0] bd_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      bd_r <= b_r;
      bo_r <= bd_r;
    end
  end
  logic signed [15:0] bf_r [9];
  always_ff @(posedge clk) begin
    if (en) bf_r <= bo_r;
  end

  assign out_side_x = bf_r[0];
  assign out_side_y = bf_r[1];
  assign out_side_z = bf_r[2];
  assign out_up_x = bf_r[3];
  assign out_up_y = bf_r[4];
  assign out_up_z = bf_r[5];
  assign out_fwd_x = bf_r[6];
  assign out_fwd_y = bf_r[7];
  assign out_fwd_z = bf_r[8];
  assign out_shift_x = sh_r[0];
  assign out_shift_y = sh_r[1];
  assign out_shift_z = sh_r[2];

  `ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMPL(a_basis_range, clk, rst_n, out_valid,
    out_fwd_z <= 16'sd16384 && out_fwd_z >= -16'sd16384)
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the yxz euler view matrix block: predicted matrices vs dut words
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AB = eyvm_pkg::ANGLE_BITS_DEF;
  localparam int CB = eyvm_pkg::COORD_BITS_DEF;
  localparam int LATENCY = 28;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [CB-1:0] px, py, pz;
    logic [AB-1:0] ax, ay, az;
  } pose_t;

  localparam int POSE_W = $bits(pose_t);

  typedef struct packed {
    logic signed [15:0] sx, sy, sz, ux, uy, uz, fx, fy, fz;
    logic signed [CB-1:0] tx, ty, tz;
  } view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [AB-1:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_side_x, out_side_y, out_side_z;
  logic signed [15:0] out_up_x, out_up_y, out_up_z;
  logic signed [15:0] out_fwd_x, out_fwd_y, out_fwd_z;
  logic signed [CB-1:0] out_shift_x, out_shift_y, out_shift_z;

  view_t view_q[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit timed_out = 1'b0;

  always #5 clk = ~clk;

  euler_yxz_view_matrix_top u_dut (.*);

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[20] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
      64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
      64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30,
      64'h00000518};
    return tbl[i];
  endfunction

  function automatic void sin_cos_q14(input logic [AB-1:0] ang, output longint s,
                                      output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed({ang, {(32 - AB){1'b0}}}));
    x = 64'h26DD3B6A;
    y = 0;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i); y = y + fshift(x, i); z -= atan_step(i);
      end else begin
        nx = x + fshift(y, i); y = y - fshift(x, i); z += atan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clampl(fshift(x + 64'h8000, 16), -16384, 16384);
    s = clampl(fshift(y + 64'h8000, 16), -16384, 16384);
  endfunction

  function automatic longint q42_round(longint v);
    return clampl(fshift(v + (64'sd1 <<< 27), 28), -16384, 16384);
  endfunction

  function automatic logic [CB-1:0] translation(longint b0, longint b1, longint b2,
                                                 longint t0, longint t1, longint t2);
    longint lim, acc;
    lim = 64'sd1 <<< (CB - 1);
    acc = -(b0 * t0 + b1 * t1 + b2 * t2);
    return CB'(clampl(fshift(acc + 64'sd8192, 14), -lim, lim - 1));
  endfunction

  function automatic view_t predict_view(pose_t p);
    longint s1, c1, s2, c2, s3, c3, t0, t1, t2;
    longint u[3], v[3], w[3];
    view_t r;
    t0 = longint'(p.px); t1 = longint'(p.pz); t2 = longint'(p.py);
    sin_cos_q14(p.az, s1, c1);
    sin_cos_q14(p.ax, s2, c2);
    sin_cos_q14(p.ay, s3, c3);
    u[0] = q42_round(c1 * c3 * 16384 + s1 * s2 * s3);
    u[1] = q42_round(c2 * s3 * 16384);
    u[2] = q42_round(c1 * s2 * s3 - c3 * s1 * 16384);
    v[0] = q42_round(c3 * s1 * s2 - c1 * s3 * 16384);
    v[1] = q42_round(c2 * c3 * 16384);
    v[2] = q42_round(c1 * c3 * s2 + s1 * s3 * 16384);
    w[0] = q42_round(c2 * s1 * 16384);
    w[1] = -s2;
    w[2] = q42_round(c1 * c2 * 16384);
    r.sx = 16'(u[0]); r.sy = 16'(u[1]); r.sz = 16'(u[2]);
    r.ux = 16'(v[0]); r.uy = 16'(v[1]); r.uz = 16'(v[2]);
    r.fx = 16'(w[0]); r.fy = 16'(w[1]); r.fz = 16'(w[2]);
    r.tx = translation(u[0], u[1], u[2], t0, t1, t2);
    r.ty = translation(v[0], v[1], v[2], t0, t1, t2);
    r.tz = translation(w[0], w[1], w[2], t0, t1, t2);
    return r;
  endfunction

  task automatic send_pose(pose_t p);
    repeat ($urandom_range(0, 3)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {in_pos_x, in_pos_y, in_pos_z} <= {p.px, p.py, p.pz};
    {in_angle_x, in_angle_y, in_angle_z} <= {p.ax, p.ay, p.az};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    view_q.push_back(predict_view(p));
    words_sent++;
  endtask

  function automatic pose_t rand_pose();
    pose_t p;
    p = POSE_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      p.px = $signed(p.px) >>> $urandom_range(0, 31);
      p.py = $signed(p.py) >>> $urandom_range(0, 31);
      p.pz = $signed(p.pz) >>> $urandom_range(0, 31);
    end
    return p;
  endfunction

  task automatic finish_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic test_extremes();
    logic [AB-1:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                               16'h4001, 16'h3FFF, 16'hBFFF};
    logic signed [CB-1:0] posv[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00010000};
    for (int i = 0; i < 8; i++)
      send_pose('{posv[i % 4], posv[(i + 1) % 4], posv[(i + 2) % 4],
                  angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8]});
    // saturation of the translation in both directions
    send_pose('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 16'h2000, 16'h2000});
    send_pose('{32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 16'h2000, 16'h2000});
    send_pose('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hE000, 16'h6000, 16'hA000});
    send_pose('{32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pose('{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'h5555, 16'hAAAA, 16'h5555});
    send_pose('{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA, 16'h5555, 16'hAAAA});
    finish_burst();
  endtask

  task automatic test_random();
    for (int i = 0; i < 600; i++) send_pose(rand_pose());
    finish_burst();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) send_pose(rand_pose());
    join
    finish_burst();
  endtask

  // result side wait draw per word, held off during the long stretch
  initial begin
    int n;
    forever begin
      if (hold_off) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        @(negedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid && !hold_off) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    view_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_side_x, out_side_y, out_side_z, out_up_x, out_up_y, out_up_z,
              out_fwd_x, out_fwd_y, out_fwd_z, out_shift_x, out_shift_y, out_shift_z};
      if (view_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = view_q.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_random();
    test_backpressure();
    while (view_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d poses (axis extremes, saturation, random, long stall), %0d checked",
             words_sent, words_checked);
    if (mismatches == 0 && view_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

FILE: euler_yxz_view_matrix_top.f
+incdir+hw/rtl
hw/rtl/eyvm_pkg.sv
hw/rtl/eyvm_cordic.sv
hw/rtl/euler_yxz_view_matrix_top.sv
tb/sv/tb.sv
